@@ src/relpk_pkg.sv @@
// ----------------------------------------------------------------------------
// relpk_pkg
// shared widths, register map and lane flag type for the relative peak
// evaluation unit
// ----------------------------------------------------------------------------
package relpk_pkg;

    localparam int PIX_W      = 8;
    localparam int EVAL_W     = 17;
    localparam int THR_W      = 17;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    // register index, taken from paddr[APB_ADDR_W-1]
    localparam logic REG_PEAK_THRESHOLD = 1'b0;

    // divide by five as (x * RECIP5) >> RECIP5_SHIFT, exact for x below 2**30
    localparam int                  RECIP5_W     = 28;
    localparam int                  RECIP5_SHIFT = 30;
    localparam logic [RECIP5_W-1:0] RECIP5       = 28'd214748365;

    typedef struct packed {
        logic neg;
        logic sat;
    } t_lane_flags;

endpackage

@@ src/relpk_pix_if.sv @@
// ----------------------------------------------------------------------------
// relpk_pix_if
// input channel: one pixel and its local area average per beat
// ----------------------------------------------------------------------------
interface relpk_pix_if import relpk_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;

    modport source (
        output valid, red, green, blue, avg_red, avg_green, avg_blue,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, avg_red, avg_green, avg_blue,
        output ready
    );

endinterface

@@ src/relpk_res_if.sv @@
// ----------------------------------------------------------------------------
// relpk_res_if
// output channel: evaluation and line flag per beat
// ----------------------------------------------------------------------------
interface relpk_res_if import relpk_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [EVAL_W-1:0] eval_value;
    logic              is_line;

    modport source (
        output valid, eval_value, is_line,
        input  ready
    );

    modport sink (
        input  valid, eval_value, is_line,
        output ready
    );

endinterface

@@ src/relative_peak_evaluate_threshold_unit.sv @@
// ----------------------------------------------------------------------------
// relative_peak_evaluate_threshold_unit
// throughput: one pixel per cycle while the output is not stalled; the channel
// lanes resolve one quotient bit per pipeline stage and the merge divides by
// five with a reciprocal multiply
// reset: synchronous, clears all beat valids, threshold returns to 32768
// ----------------------------------------------------------------------------
module relative_peak_evaluate_threshold_unit import relpk_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    relpk_pix_if.sink              i_pix,
    relpk_res_if.source            o_res,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int QW  = PIX_W + FRAC_BITS;
    localparam int UW  = QW + 3;
    localparam int LAT = QW + 4;

    // config register
    logic [THR_W-1:0] r_thr;
    logic             w_reg_sel;

    assign w_reg_sel = (paddr[APB_ADDR_W-1] == REG_PEAK_THRESHOLD);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? {{(APB_DATA_W-THR_W){1'b0}}, r_thr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // pipeline control
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en        = !r_vld[LAT-1] || o_res.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pix.valid};
        end
    end

    // channel lanes
    logic [QW-1:0] w_quot_r;
    logic [QW-1:0] w_quot_g;
    logic [QW-1:0] w_quot_b;
    t_lane_flags   w_flags_r;
    t_lane_flags   w_flags_g;
    t_lane_flags   w_flags_b;

    relpk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pix   (i_pix.red),
        .i_avg   (i_pix.avg_red),
        .o_quot  (w_quot_r),
        .o_flags (w_flags_r)
    );

    relpk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pix   (i_pix.green),
        .i_avg   (i_pix.avg_green),
        .o_quot  (w_quot_g),
        .o_flags (w_flags_g)
    );

    relpk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pix   (i_pix.blue),
        .i_avg   (i_pix.avg_blue),
        .o_quot  (w_quot_b),
        .o_flags (w_flags_b)
    );

    // merge and divide by five
    logic [UW-1:0] w_eval;

    relpk_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_quot_r  (w_quot_r),
        .i_quot_g  (w_quot_g),
        .i_quot_b  (w_quot_b),
        .i_flags_r (w_flags_r),
        .i_flags_g (w_flags_g),
        .i_flags_b (w_flags_b),
        .o_eval    (w_eval)
    );

    // output register
    logic [EVAL_W-1:0] r_eval;
    logic              r_is_line;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_eval    <= w_eval[EVAL_W-1:0];
            r_is_line <= (w_eval >= {{(UW-THR_W){1'b0}}, r_thr});
        end
    end

    assign o_res.valid      = r_vld[LAT-1];
    assign o_res.eval_value = r_eval;
    assign o_res.is_line    = r_is_line;

    // checks
    a_line_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.is_line |-> o_res.eval_value < r_thr)
        else $error("line flag clear with evaluation at or above threshold");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_beat_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted beat not tracked in first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

endmodule

@@ src/relpk_lane.sv @@
// ----------------------------------------------------------------------------
// relpk_lane
// one color channel: relative excess (pix - avg) / (255 - avg) as a
// magnitude quotient with FRAC_BITS fraction bits, one quotient bit per stage
// ----------------------------------------------------------------------------
module relpk_lane import relpk_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [PIX_W-1:0]            i_pix,
    input  logic [PIX_W-1:0]            i_avg,
    output logic [PIX_W+FRAC_BITS-1:0]  o_quot,
    output t_lane_flags                 o_flags
);

    localparam int QW = PIX_W + FRAC_BITS;

    logic [PIX_W-1:0] r_mag   [QW+1];
    logic [PIX_W-1:0] r_den   [QW+1];
    logic [PIX_W-1:0] r_rem   [QW+1];
    logic [QW-1:0]    r_quot  [QW+1];
    t_lane_flags      r_flags [QW+1];

    logic             n_neg;
    logic [PIX_W-1:0] n_mag;

    always_comb begin
        n_neg = (i_pix < i_avg);
        n_mag = n_neg ? (i_avg - i_pix) : (i_pix - i_avg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0]       <= n_mag;
            r_den[0]       <= {PIX_W{1'b1}} - i_avg;
            r_rem[0]       <= '0;
            r_quot[0]      <= '0;
            r_flags[0].neg <= n_neg;
            r_flags[0].sat <= (i_avg == {PIX_W{1'b1}});
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int BIT = QW - 1 - k;

        logic             w_bit;
        logic [PIX_W:0]   w_trial;
        logic [PIX_W:0]   w_diff;
        logic             w_ge;

        if (BIT >= FRAC_BITS) begin : g_num
            assign w_bit = r_mag[k][BIT-FRAC_BITS];
        end else begin : g_zero
            assign w_bit = 1'b0;
        end

        assign w_trial = {r_rem[k], w_bit};
        assign w_diff  = w_trial - {1'b0, r_den[k]};
        assign w_ge    = (w_trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[k+1]   <= r_mag[k];
                r_den[k+1]   <= r_den[k];
                r_flags[k+1] <= r_flags[k];
                r_rem[k+1]   <= w_ge ? w_diff[PIX_W-1:0] : w_trial[PIX_W-1:0];
                r_quot[k+1]  <= {r_quot[k][QW-2:0], w_ge};
            end
        end
    end

    assign o_quot  = r_quot[QW];
    assign o_flags = r_flags[QW];

endmodule

@@ src/relpk_merge.sv @@
// ----------------------------------------------------------------------------
// relpk_merge
// weighted sum 3*r + g + b of the lane results, clamp at zero, then divide
// by five with a reciprocal multiply over two register stages
// ----------------------------------------------------------------------------
module relpk_merge import relpk_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [PIX_W+FRAC_BITS-1:0]   i_quot_r,
    input  logic [PIX_W+FRAC_BITS-1:0]   i_quot_g,
    input  logic [PIX_W+FRAC_BITS-1:0]   i_quot_b,
    input  t_lane_flags                  i_flags_r,
    input  t_lane_flags                  i_flags_g,
    input  t_lane_flags                  i_flags_b,
    output logic [PIX_W+FRAC_BITS+2:0]   o_eval
);

    localparam int QW = PIX_W + FRAC_BITS;
    localparam int SW = QW + 4;
    localparam int UW = SW - 1;
    // clamped sum never exceeds 5 << FRAC_BITS
    localparam int NW = FRAC_BITS + 3;
    localparam int PW = NW + RECIP5_W;
    localparam int DW = PW - RECIP5_SHIFT;

    function automatic logic signed [SW-1:0] to_rel(
        input logic [QW-1:0] q,
        input t_lane_flags   f
    );
        logic signed [SW-1:0] mag;
        logic signed [SW-1:0] half;
        mag  = signed'({{(SW-QW){1'b0}}, q});
        half = signed'({{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
        if (f.sat) begin
            to_rel = half;
        end else if (f.neg) begin
            to_rel = -mag;
        end else begin
            to_rel = mag;
        end
    endfunction

    logic signed [SW-1:0] w_rel_r;
    logic signed [SW-1:0] w_rel_g;
    logic signed [SW-1:0] w_rel_b;
    logic signed [SW-1:0] w_sum;

    always_comb begin
        w_rel_r = to_rel(i_quot_r, i_flags_r);
        w_rel_g = to_rel(i_quot_g, i_flags_g);
        w_rel_b = to_rel(i_quot_b, i_flags_b);
        w_sum   = (w_rel_r <<< 1) + w_rel_r + w_rel_g + w_rel_b;
    end

    logic [NW-1:0] r_num;
    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= (w_sum > 0) ? w_sum[NW-1:0] : '0;
            r_prod <= r_num * RECIP5;
        end
    end

    assign o_eval = {{(UW-DW){1'b0}}, r_prod[PW-1:RECIP5_SHIFT]};

endmodule
